// ===== hdl/wfrq_pkg.sv =====
// Shared types, constants and helpers for the weighted fair run queue.
// No dependencies; weighted_fair_run_queue_unit imports this package.
`timescale 1ns / 1ps

package wfrq_pkg;

   localparam int TIME_W        = 32;
   localparam int GRAN_W        = 20;
   localparam int WEIGHT_W      = 17;
   localparam int PRIO_W        = 6;
   localparam int ID_W          = 8;
   localparam int OP_W          = 3;
   localparam int ST_W          = 2;
   localparam int VSHIFT        = 10;     // charge scale of 1024
   localparam int PRIO_MAX      = 39;
   localparam int LAT_MIN_PROCS = 20;
   localparam int MAX_PROCS_DEF = 64;
   localparam logic [GRAN_W-1:0] GRAN_RESET = GRAN_W'(10);
   localparam logic [TIME_W-1:0] TIME_MAX   = '1;

   // request codes
   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
   localparam logic [OP_W-1:0] OP_CHECK  = 3'd2;
   localparam logic [OP_W-1:0] OP_SCHED  = 3'd3;
   localparam logic [OP_W-1:0] OP_YIELD  = 3'd4;

   // status codes
   localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
   localparam logic [ST_W-1:0] ST_NONE   = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
   localparam logic [ST_W-1:0] ST_NO_RUN = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   req_type;
      logic [ID_W-1:0]   proc_id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] vruntime;
      logic [TIME_W-1:0] burst_time;
      logic [TIME_W-1:0] time_now;
   } req_item_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic [ID_W-1:0]   out_proc_id;
      logic [TIME_W-1:0] out_vruntime;
      logic [TIME_W-1:0] timeslice;
      logic              preempt_pending;
      logic              queue_empty;
   } rsp_item_type;

   // one waiting process as stored in the table memory
   typedef struct packed {
      logic [TIME_W-1:0] key;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] burst;
   } entry_type;

   function automatic logic [WEIGHT_W-1:0] weight_of(input logic [PRIO_W-1:0] prio);
      logic [WEIGHT_W-1:0] w;
      case (prio)
         6'd0:  w = 17'd88761;  6'd1:  w = 17'd71755;  6'd2:  w = 17'd56483;
         6'd3:  w = 17'd46273;  6'd4:  w = 17'd36291;  6'd5:  w = 17'd29154;
         6'd6:  w = 17'd23254;  6'd7:  w = 17'd18705;  6'd8:  w = 17'd14949;
         6'd9:  w = 17'd11916;  6'd10: w = 17'd9548;   6'd11: w = 17'd7620;
         6'd12: w = 17'd6100;   6'd13: w = 17'd4904;   6'd14: w = 17'd3906;
         6'd15: w = 17'd3121;   6'd16: w = 17'd2501;   6'd17: w = 17'd1991;
         6'd18: w = 17'd1586;   6'd19: w = 17'd1277;   6'd20: w = 17'd1024;
         6'd21: w = 17'd820;    6'd22: w = 17'd655;    6'd23: w = 17'd526;
         6'd24: w = 17'd423;    6'd25: w = 17'd335;    6'd26: w = 17'd272;
         6'd27: w = 17'd215;    6'd28: w = 17'd172;    6'd29: w = 17'd137;
         6'd30: w = 17'd110;    6'd31: w = 17'd87;     6'd32: w = 17'd70;
         6'd33: w = 17'd56;     6'd34: w = 17'd45;     6'd35: w = 17'd36;
         6'd36: w = 17'd29;     6'd37: w = 17'd23;     6'd38: w = 17'd18;
         default: w = 17'd15;
      endcase
      return w;
   endfunction

   // add, pinned at the top of the time range
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

endpackage

// ===== hdl/weighted_fair_run_queue_unit.sv =====
// Weighted fair run queue: waiting-process table in RAM, one running process.
// Depends on wfrq_pkg, wfrq_ram and wfrq_div.
//
//   channel  ports                          direction  transfer when
//   req      req_valid/req_ready/req_data   in         valid and ready high
//   rsp      rsp_valid/rsp_ready/rsp_data   out        valid and ready high
//   csr      csr_wr_en/csr_wr_data          in         write enable high
//
// One request at a time. Yield finishes on acceptance; add computes the
// target latency, then enqueues. Update, preempt check and schedule walk the
// table through the RAM read port; check (when a waiting entry is no later)
// and schedule then compute the target latency and its product. Update runs
// the serial divider, check and schedule too when the load is nonzero;
// schedule also takes the entry and compacts the table behind it, one entry
// per cycle. A preempt check that re-queues then enqueues the running process.
// Synchronous reset clears control state; the table needs no clearing pass.
// A finished result waits in the output register while the next request is
// taken; the block stalls only when a second result is ready before that.
`timescale 1ns / 1ps

module weighted_fair_run_queue_unit #(
   parameter int MAX_PROCS = wfrq_pkg::MAX_PROCS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  wfrq_pkg::req_item_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output wfrq_pkg::rsp_item_type        rsp_data,
   input  logic                          csr_wr_en,
   input  logic [wfrq_pkg::GRAN_W-1:0]   csr_wr_data
);

   import wfrq_pkg::*;

   localparam int ADDR_W  = $clog2(MAX_PROCS);
   localparam int CNT_W   = $clog2(MAX_PROCS + 1);
   localparam int TOT_W   = $clog2(MAX_PROCS + 2);
   localparam int LOAD_W  = WEIGHT_W + TOT_W;
   localparam int NPROC_W = (TOT_W > 5) ? TOT_W : 5;
   localparam int TL_W    = GRAN_W + NPROC_W;
   localparam int PROD_W  = TL_W + WEIGHT_W;
   localparam int DIV_W   = (PROD_W > TIME_W + VSHIFT) ? PROD_W : TIME_W + VSHIFT;
   localparam int CMP_W   = (TL_W > TIME_W) ? TL_W : TIME_W;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_SCAN  = 12'b0000_0000_0010,
      S_TAKE  = 12'b0000_0000_0100,
      S_SHIFT = 12'b0000_0000_1000,
      S_TLS   = 12'b0000_0001_0000,
      S_MUL   = 12'b0000_0010_0000,
      S_DST   = 12'b0000_0100_0000,
      S_DIV   = 12'b0000_1000_0000,
      S_SLICE = 12'b0001_0000_0000,
      S_TLE   = 12'b0010_0000_0000,
      S_ENQ   = 12'b0100_0000_0000,
      S_FIN   = 12'b1000_0000_0000
   } state_type;

   state_type            state_ff, state_in;
   req_item_type         req_ff, req_in;
   rsp_item_type         res_ff, res_in;
   rsp_item_type         rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [GRAN_W-1:0]    gran_ff, gran_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [LOAD_W-1:0]    load_ff, load_in;
   logic                 run_valid_ff, run_valid_in;
   logic [ID_W-1:0]      run_id_ff, run_id_in;
   logic [PRIO_W-1:0]    run_prio_ff, run_prio_in;
   logic [TIME_W-1:0]    run_vtime_ff, run_vtime_in;
   logic [TIME_W-1:0]    run_burst_ff, run_burst_in;
   logic [TIME_W-1:0]    run_last_ff, run_last_in;
   logic [TIME_W-1:0]    run_start_ff, run_start_in;
   logic [TIME_W-1:0]    run_slice_ff, run_slice_in;
   logic [TIME_W-1:0]    floor_ff, floor_in;
   logic                 flag_ff, flag_in;
   logic [CNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [ADDR_W-1:0]    chk_idx_ff, chk_idx_in;
   logic                 best_found_ff, best_found_in;
   entry_type            best_ff, best_in;
   logic [ADDR_W-1:0]    best_idx_ff, best_idx_in;
   logic [TL_W-1:0]      tl_ff, tl_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr, ram_raddr;
   entry_type            ram_wdata, ram_rdata;
   logic                 div_start, div_done;
   logic [DIV_W-1:0]     div_dividend, div_quo;
   logic [LOAD_W-1:0]    div_divisor;

   logic [WEIGHT_W-1:0]  run_w;
   logic [LOAD_W-1:0]    run_w_ext;
   logic [NPROC_W-1:0]   nproc;
   logic [TL_W-1:0]      tl_calc;
   logic [TIME_W-1:0]    dt;
   logic [TIME_W-1:0]    charge;
   logic [TIME_W-1:0]    vnew;
   logic [TIME_W-1:0]    vmin;
   logic [TIME_W-1:0]    slice;
   logic                 table_full;
   entry_type            enq_src;
   logic [TIME_W-1:0]    enq_key;
   logic [CMP_W-1:0]     floor_ext, tl_ext, lag_floor;

   wfrq_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (MAX_PROCS)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wfrq_div #(
      .DVD_W (DIV_W),
      .DSR_W (LOAD_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // shared arithmetic on the current state
   assign run_w      = weight_of(run_prio_ff);
   assign run_w_ext  = LOAD_W'(run_w);
   assign nproc      = (NPROC_W'(total_ff) > NPROC_W'(LAT_MIN_PROCS))
                       ? NPROC_W'(total_ff) : NPROC_W'(LAT_MIN_PROCS);
   assign tl_calc    = TL_W'(gran_ff) * TL_W'(nproc);
   assign dt         = req_ff.time_now - run_last_ff;
   assign charge     = (|div_quo[DIV_W-1:TIME_W]) ? TIME_MAX : div_quo[TIME_W-1:0];
   assign vnew       = sat_add(run_vtime_ff, charge);
   assign vmin       = (best_found_ff && vnew > best_ff.key) ? best_ff.key : vnew;
   assign slice      = (load_ff == '0) ? '0 : charge;
   assign table_full = count_ff >= CNT_W'(MAX_PROCS);

   // entry to enqueue: the request's process for add, the running one otherwise
   always_comb begin
      if (req_ff.req_type == OP_ADD) begin
         enq_src.key   = req_ff.vruntime;
         enq_src.id    = req_ff.proc_id;
         enq_src.prio  = req_ff.prio;
         enq_src.burst = req_ff.burst_time;
      end else begin
         enq_src.key   = run_vtime_ff;
         enq_src.id    = run_id_ff;
         enq_src.prio  = run_prio_ff;
         enq_src.burst = run_burst_ff;
      end
   end

   // pull new and io-returning processes close to the floor
   assign floor_ext = CMP_W'(floor_ff);
   assign tl_ext    = CMP_W'(tl_ff);
   assign lag_floor = floor_ext - tl_ext;
   always_comb begin
      enq_key = enq_src.key;
      if (enq_src.key == '0 && floor_ff > TIME_W'(gran_ff)) begin
         enq_key = floor_ff - TIME_W'(gran_ff);
      end else if (enq_src.burst == '0 && floor_ext >= tl_ext &&
                   CMP_W'(enq_src.key) < lag_floor) begin
         enq_key = TIME_W'(lag_floor);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      gran_in       = gran_ff;
      count_in      = count_ff;
      total_in      = total_ff;
      load_in       = load_ff;
      run_valid_in  = run_valid_ff;
      run_id_in     = run_id_ff;
      run_prio_in   = run_prio_ff;
      run_vtime_in  = run_vtime_ff;
      run_burst_in  = run_burst_ff;
      run_last_in   = run_last_ff;
      run_start_in  = run_start_ff;
      run_slice_in  = run_slice_ff;
      floor_in      = floor_ff;
      flag_in       = flag_ff;
      rd_idx_in     = rd_idx_ff;
      chk_vld_in    = chk_vld_ff;
      chk_idx_in    = chk_idx_ff;
      best_found_in = best_found_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      tl_in         = tl_ff;
      prod_in       = prod_ff;
      ram_we        = 1'b0;
      ram_waddr     = count_ff[ADDR_W-1:0];
      ram_wdata     = ram_rdata;
      ram_raddr     = rd_idx_ff[ADDR_W-1:0];
      div_start     = 1'b0;
      div_dividend  = (req_ff.req_type == OP_UPDATE)
                      ? DIV_W'({dt, {VSHIFT{1'b0}}}) : DIV_W'(prod_ff);
      div_divisor   = (req_ff.req_type == OP_UPDATE) ? run_w_ext : load_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               if (req_data.prio > PRIO_W'(PRIO_MAX)) begin
                  req_in.prio = PRIO_W'(PRIO_MAX);
               end
               res_in        = '0;
               res_in.status = ST_NONE;
               rd_idx_in     = '0;
               chk_vld_in    = 1'b0;
               best_found_in = 1'b0;
               state_in      = S_FIN;
               case (req_data.req_type)
                  OP_ADD: begin
                     if (table_full) begin
                        res_in.status = ST_FULL;
                     end else begin
                        state_in = S_TLE;
                     end
                  end
                  OP_UPDATE, OP_CHECK: begin
                     if (!run_valid_ff) begin
                        res_in.status = ST_NO_RUN;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_YIELD: begin
                     if (!run_valid_ff) begin
                        res_in.status = ST_NO_RUN;
                     end else begin
                        // drop the running process
                        res_in.status       = ST_DONE;
                        res_in.out_proc_id  = run_id_ff;
                        res_in.out_vruntime = run_vtime_ff;
                        run_valid_in        = 1'b0;
                        if (total_ff != '0) begin
                           total_in = total_ff - 1'b1;
                        end
                        load_in = (load_ff >= run_w_ext) ? load_ff - run_w_ext : '0;
                     end
                  end
                  OP_SCHED: begin
                     if (!run_valid_ff) begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         S_SCAN: begin
            // issue one read per cycle, compare in the cycle after
            chk_vld_in = 1'b0;
            if (rd_idx_ff < count_ff) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[ADDR_W-1:0];
            end
            if (chk_vld_ff && (!best_found_ff || ram_rdata.key < best_ff.key)) begin
               best_in       = ram_rdata;
               best_idx_in   = chk_idx_ff;
               best_found_in = 1'b1;
            end
            if (rd_idx_ff == count_ff && !chk_vld_ff) begin
               case (req_ff.req_type)
                  OP_UPDATE: begin
                     state_in = S_DST;
                  end
                  OP_CHECK: begin
                     res_in.out_proc_id  = run_id_ff;
                     res_in.out_vruntime = run_vtime_ff;
                     res_in.timeslice    = run_slice_ff;
                     if (!best_found_ff || best_ff.key > run_vtime_ff) begin
                        state_in = S_FIN;
                     end else begin
                        state_in = S_TLS;
                     end
                  end
                  OP_SCHED: begin
                     state_in = best_found_ff ? S_TAKE : S_FIN;
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         S_TAKE: begin
            // start the minimum entry running
            run_valid_in = 1'b1;
            run_id_in    = best_ff.id;
            run_prio_in  = best_ff.prio;
            run_vtime_in = best_ff.key;
            run_burst_in = best_ff.burst;
            run_last_in  = req_ff.time_now;
            run_start_in = req_ff.time_now;
            rd_idx_in    = CNT_W'(best_idx_ff) + 1'b1;
            chk_vld_in   = 1'b0;
            state_in     = S_SHIFT;
         end

         S_SHIFT: begin
            // move later entries down by one to keep arrival order
            chk_vld_in = 1'b0;
            if (rd_idx_ff < count_ff) begin
               rd_idx_in  = rd_idx_ff + 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[ADDR_W-1:0];
            end
            if (chk_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = chk_idx_ff - 1'b1;
               ram_wdata = ram_rdata;
            end
            if (rd_idx_ff == count_ff && !chk_vld_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_TLS;
            end
         end

         S_TLS: begin
            tl_in    = tl_calc;
            state_in = S_MUL;
         end

         S_MUL: begin
            prod_in  = PROD_W'(tl_ff) * PROD_W'(run_w);
            state_in = S_DST;
         end

         S_DST: begin
            if (req_ff.req_type == OP_UPDATE || load_ff != '0) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end else begin
               state_in = S_SLICE;
            end
         end

         S_DIV: begin
            if (div_done) begin
               if (req_ff.req_type == OP_UPDATE) begin
                  // charge elapsed time and advance the floor
                  run_last_in         = req_ff.time_now;
                  run_burst_in        = sat_add(run_burst_ff, dt);
                  run_vtime_in        = vnew;
                  if (floor_ff < vmin) begin
                     floor_in = vmin;
                  end
                  res_in.status       = ST_DONE;
                  res_in.out_proc_id  = run_id_ff;
                  res_in.out_vruntime = vnew;
                  state_in            = S_FIN;
               end else begin
                  state_in = S_SLICE;
               end
            end
         end

         S_SLICE: begin
            run_slice_in        = slice;
            res_in.out_proc_id  = run_id_ff;
            res_in.out_vruntime = run_vtime_ff;
            res_in.timeslice    = slice;
            state_in            = S_FIN;
            if (req_ff.req_type == OP_SCHED) begin
               res_in.status = ST_DONE;
            end else if (req_ff.time_now >= sat_add(run_start_ff, slice) || flag_ff) begin
               if (table_full) begin
                  res_in.status = ST_FULL;
               end else begin
                  // re-queue the running process
                  flag_in      = 1'b0;
                  run_valid_in = 1'b0;
                  if (total_ff != '0) begin
                     total_in = total_ff - 1'b1;
                  end
                  load_in  = (load_ff >= run_w_ext) ? load_ff - run_w_ext : '0;
                  state_in = S_TLE;
               end
            end
         end

         S_TLE: begin
            tl_in    = tl_calc;
            state_in = S_ENQ;
         end

         S_ENQ: begin
            ram_we              = 1'b1;
            ram_waddr           = count_ff[ADDR_W-1:0];
            ram_wdata           = enq_src;
            ram_wdata.key       = enq_key;
            count_in            = count_ff + 1'b1;
            total_in            = total_ff + 1'b1;
            load_in             = load_ff + LOAD_W'(weight_of(enq_src.prio));
            res_in.status       = ST_DONE;
            res_in.out_vruntime = enq_key;
            if (req_ff.req_type == OP_ADD) begin
               flag_in                = run_valid_ff && enq_key < run_vtime_ff;
               res_in.out_proc_id     = req_ff.proc_id;
               res_in.preempt_pending = run_valid_ff && enq_key < run_vtime_ff;
            end else begin
               run_vtime_in = enq_key;
            end
            state_in = S_FIN;
         end

         S_FIN: begin
            // hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in             = res_ff;
               rsp_data_in.queue_empty = !run_valid_ff && count_ff == '0;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_wr_en) begin
         gran_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         gran_ff       <= GRAN_RESET;
         count_ff      <= '0;
         total_ff      <= '0;
         load_ff       <= '0;
         run_valid_ff  <= 1'b0;
         run_id_ff     <= '0;
         run_prio_ff   <= '0;
         run_vtime_ff  <= '0;
         run_burst_ff  <= '0;
         run_last_ff   <= '0;
         run_start_ff  <= '0;
         run_slice_ff  <= '0;
         floor_ff      <= '0;
         flag_ff       <= 1'b0;
         chk_vld_ff    <= 1'b0;
         best_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         gran_ff       <= gran_in;
         count_ff      <= count_in;
         total_ff      <= total_in;
         load_ff       <= load_in;
         run_valid_ff  <= run_valid_in;
         run_id_ff     <= run_id_in;
         run_prio_ff   <= run_prio_in;
         run_vtime_ff  <= run_vtime_in;
         run_burst_ff  <= run_burst_in;
         run_last_ff   <= run_last_in;
         run_start_ff  <= run_start_in;
         run_slice_ff  <= run_slice_in;
         floor_ff      <= floor_in;
         flag_ff       <= flag_in;
         chk_vld_ff    <= chk_vld_in;
         best_found_ff <= best_found_in;
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      rd_idx_ff   <= rd_idx_in;
      chk_idx_ff  <= chk_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      tl_ff       <= tl_in;
      prod_ff     <= prod_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== hdl/wfrq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module wfrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== hdl/wfrq_div.sv =====
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module wfrq_div #(
   parameter int DVD_W = 44,
   parameter int DSR_W = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DSR_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DSR_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [DSR_W:0]   shifted;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign fits    = shifted >= {1'b0, dsr_ff};

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DSR_W'(shifted - {1'b0, dsr_ff}) : shifted[DSR_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
